@@ rtl/core/ffbh_pkg.sv @@
// Package for the first-fit block heap manager.
// Holds shared codes, widths and the controller/datapath command and status structs.
// No dependencies.
package ffbh_pkg;

    // Heap size default and fixed field widths
    localparam int HEAP_BYTES_DEF = 128;
    localparam int PW             = 9;   // walk position, holds an offset past the heap
    localparam int IN_W           = 32;  // 26 bits of fields, padded to whole bytes
    localparam int OUT_W          = 64;  // 57 bits of fields, padded to whole bytes

    // Size byte layout
    localparam logic [7:0] ALLOC_BIT = 8'h01;
    localparam logic [7:0] SIZE_MASK = 8'hFE;
    localparam logic [6:0] SPLIT_MIN = 7'd2;

    typedef enum logic [2:0] {
        OP_ALLOC = 3'd0,
        OP_FREE  = 3'd1,
        OP_FILL  = 3'd2,
        OP_READ  = 3'd3,
        OP_HDR   = 3'd4,
        OP_LIST  = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOSPACE  = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_REJECT   = 2'd3
    } res_status_t;

    typedef enum logic [2:0] {
        RK_PLAIN = 3'd0,
        RK_ALLOC = 3'd1,
        RK_READ  = 3'd2,
        RK_HDR   = 3'd3,
        RK_LIST  = 3'd4
    } res_kind_t;

    typedef enum logic {
        RS_HDR  = 1'b0,
        RS_BYTE = 1'b1
    } rsel_t;

    typedef enum logic [2:0] {
        WS_REM_ID  = 3'd0,
        WS_REM_SZ  = 3'd1,
        WS_ID      = 3'd2,
        WS_SZ_AMT  = 3'd3,
        WS_SZ_KEEP = 3'd4,
        WS_FREE    = 3'd5,
        WS_FILL    = 3'd6
    } wsel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_WALK_RD,
        S_CHK,
        S_ACT,
        S_WR_REM_ID,
        S_WR_REM_SZ,
        S_WR_ID,
        S_WR_SZ,
        S_FILL,
        S_RD_BYTE,
        S_RD_WAIT,
        S_EMIT,
        S_LIST_EMIT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic        load_in;
        rsel_t       rsel;
        logic        we;
        wsel_t       wsel;
        logic        cap;
        logic        cap_byte;
        logic        adv_cur;
        logic        adv_lat;
        logic        cnt_inc;
        logic        n_inc;
        logic        load_out;
        res_status_t res_status;
        res_kind_t   res_kind;
    } ffbh_cmd_t;

    // Datapath to controller
    typedef struct packed {
        op_t  op;
        logic fit;
        logic match;
        logic at_end;
        logic split;
        logic fill_big;
        logic sz_zero;
        logic used;
        logic lst_last;
        logic fill_done;
        logic out_free;
    } ffbh_sts_t;

endpackage

@@ rtl/core/ffbh_ctrl.sv @@
// Controller state machine of the first-fit block heap manager.
// Depends on ffbh_pkg for the state type and the command/status structs.
module ffbh_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_fire,
    output logic               in_ready,
    input  ffbh_pkg::ffbh_sts_t sts,
    output ffbh_pkg::ffbh_cmd_t cmd
);

    ffbh_pkg::state_t      state_reg, state_next;
    ffbh_pkg::res_status_t rstat_reg, rstat_next;
    ffbh_pkg::res_kind_t   rkind_reg, rkind_next;

    // State and pending result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffbh_pkg::S_IDLE;
            rstat_reg <= ffbh_pkg::ST_OK;
            rkind_reg <= ffbh_pkg::RK_PLAIN;
        end
        else
        begin
            state_reg <= state_next;
            rstat_reg <= rstat_next;
            rkind_reg <= rkind_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        rstat_next = rstat_reg;
        rkind_next = rkind_reg;
        case (state_reg)
            ffbh_pkg::S_IDLE:
            begin
                if (in_fire)
                    state_next = ffbh_pkg::S_DISPATCH;
            end
            ffbh_pkg::S_DISPATCH:
            begin
                case (sts.op)
                    ffbh_pkg::OP_ALLOC, ffbh_pkg::OP_FREE, ffbh_pkg::OP_FILL,
                    ffbh_pkg::OP_READ, ffbh_pkg::OP_HDR, ffbh_pkg::OP_LIST:
                        state_next = ffbh_pkg::S_WALK_RD;
                    default:
                        state_next = ffbh_pkg::S_IDLE;
                endcase
            end
            ffbh_pkg::S_WALK_RD:
                state_next = ffbh_pkg::S_CHK;
            ffbh_pkg::S_CHK:
            begin
                case (sts.op)
                    ffbh_pkg::OP_LIST:
                        state_next = ffbh_pkg::S_LIST_EMIT;
                    ffbh_pkg::OP_ALLOC:
                    begin
                        if (sts.fit)
                            state_next = ffbh_pkg::S_ACT;
                        else if (sts.at_end)
                        begin
                            rstat_next = ffbh_pkg::ST_NOSPACE;
                            rkind_next = ffbh_pkg::RK_PLAIN;
                            state_next = ffbh_pkg::S_EMIT;
                        end
                        else
                            state_next = ffbh_pkg::S_WALK_RD;
                    end
                    default:
                    begin
                        if (sts.match)
                            state_next = ffbh_pkg::S_ACT;
                        else if (sts.at_end)
                        begin
                            rstat_next = ffbh_pkg::ST_NOTFOUND;
                            rkind_next = ffbh_pkg::RK_PLAIN;
                            state_next = ffbh_pkg::S_EMIT;
                        end
                        else
                            state_next = ffbh_pkg::S_WALK_RD;
                    end
                endcase
            end
            ffbh_pkg::S_ACT:
            begin
                rstat_next = ffbh_pkg::ST_OK;
                rkind_next = ffbh_pkg::RK_PLAIN;
                case (sts.op)
                    ffbh_pkg::OP_ALLOC:
                        state_next = sts.split ? ffbh_pkg::S_WR_REM_ID : ffbh_pkg::S_WR_ID;
                    ffbh_pkg::OP_FREE:
                        state_next = ffbh_pkg::S_EMIT;
                    ffbh_pkg::OP_FILL:
                    begin
                        if (sts.fill_big)
                        begin
                            rstat_next = ffbh_pkg::ST_REJECT;
                            state_next = ffbh_pkg::S_EMIT;
                        end
                        else
                            state_next = ffbh_pkg::S_FILL;
                    end
                    ffbh_pkg::OP_READ:
                    begin
                        if (sts.sz_zero)
                        begin
                            rstat_next = ffbh_pkg::ST_REJECT;
                            state_next = ffbh_pkg::S_EMIT;
                        end
                        else
                            state_next = ffbh_pkg::S_RD_BYTE;
                    end
                    ffbh_pkg::OP_HDR:
                    begin
                        if (!sts.used)
                            rstat_next = ffbh_pkg::ST_REJECT;
                        else
                            rkind_next = ffbh_pkg::RK_HDR;
                        state_next = ffbh_pkg::S_EMIT;
                    end
                    default:
                        state_next = ffbh_pkg::S_IDLE;
                endcase
            end
            ffbh_pkg::S_WR_REM_ID:
                state_next = ffbh_pkg::S_WR_REM_SZ;
            ffbh_pkg::S_WR_REM_SZ:
                state_next = ffbh_pkg::S_WR_ID;
            ffbh_pkg::S_WR_ID:
                state_next = ffbh_pkg::S_WR_SZ;
            ffbh_pkg::S_WR_SZ:
            begin
                rstat_next = ffbh_pkg::ST_OK;
                rkind_next = ffbh_pkg::RK_ALLOC;
                state_next = ffbh_pkg::S_EMIT;
            end
            ffbh_pkg::S_FILL:
            begin
                if (sts.fill_done)
                    state_next = ffbh_pkg::S_EMIT;
            end
            ffbh_pkg::S_RD_BYTE:
                state_next = ffbh_pkg::S_RD_WAIT;
            ffbh_pkg::S_RD_WAIT:
            begin
                rkind_next = ffbh_pkg::RK_READ;
                state_next = ffbh_pkg::S_EMIT;
            end
            ffbh_pkg::S_EMIT:
            begin
                if (sts.out_free)
                    state_next = ffbh_pkg::S_IDLE;
            end
            ffbh_pkg::S_LIST_EMIT:
            begin
                if (sts.out_free)
                    state_next = sts.lst_last ? ffbh_pkg::S_IDLE : ffbh_pkg::S_WALK_RD;
            end
            default:
                state_next = ffbh_pkg::S_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.rsel       = ffbh_pkg::RS_HDR;
        cmd.wsel       = ffbh_pkg::WS_ID;
        cmd.res_status = rstat_reg;
        cmd.res_kind   = rkind_reg;
        case (state_reg)
            ffbh_pkg::S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_fire;
            end
            ffbh_pkg::S_CHK:
            begin
                cmd.cap = 1'b1;
                // step to next header unless this block fits/matches or is last
                if (sts.op == ffbh_pkg::OP_ALLOC)
                    cmd.adv_cur = !sts.fit && !sts.at_end;
                else if (sts.op != ffbh_pkg::OP_LIST)
                    cmd.adv_cur = !sts.match && !sts.at_end;
            end
            ffbh_pkg::S_ACT:
            begin
                if (sts.op == ffbh_pkg::OP_FREE)
                begin
                    cmd.we   = 1'b1;
                    cmd.wsel = ffbh_pkg::WS_FREE;
                end
            end
            ffbh_pkg::S_WR_REM_ID:
            begin
                cmd.we   = 1'b1;
                cmd.wsel = ffbh_pkg::WS_REM_ID;
            end
            ffbh_pkg::S_WR_REM_SZ:
            begin
                cmd.we   = 1'b1;
                cmd.wsel = ffbh_pkg::WS_REM_SZ;
            end
            ffbh_pkg::S_WR_ID:
            begin
                cmd.we   = 1'b1;
                cmd.wsel = ffbh_pkg::WS_ID;
            end
            ffbh_pkg::S_WR_SZ:
            begin
                cmd.we   = 1'b1;
                cmd.wsel = sts.split ? ffbh_pkg::WS_SZ_AMT : ffbh_pkg::WS_SZ_KEEP;
            end
            ffbh_pkg::S_FILL:
            begin
                cmd.we      = !sts.fill_done;
                cmd.wsel    = ffbh_pkg::WS_FILL;
                cmd.cnt_inc = !sts.fill_done;
            end
            ffbh_pkg::S_RD_BYTE:
                cmd.rsel = ffbh_pkg::RS_BYTE;
            ffbh_pkg::S_RD_WAIT:
                cmd.cap_byte = 1'b1;
            ffbh_pkg::S_EMIT:
                cmd.load_out = sts.out_free;
            ffbh_pkg::S_LIST_EMIT:
            begin
                cmd.load_out   = sts.out_free;
                cmd.res_status = ffbh_pkg::ST_OK;
                cmd.res_kind   = ffbh_pkg::RK_LIST;
                cmd.adv_lat    = sts.out_free && !sts.lst_last;
                cmd.n_inc      = sts.out_free && !sts.lst_last;
            end
            default:
                in_ready = 1'b0;
        endcase
    end

endmodule

@@ rtl/core/ffbh_dp.sv @@
// Datapath of the first-fit block heap manager: heap memory, walk registers, result register.
// Depends on ffbh_pkg for widths, codes and the command/status structs.
module ffbh_dp
#(
    parameter int HEAP_BYTES = ffbh_pkg::HEAP_BYTES_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [ffbh_pkg::IN_W-1:0]   in_data,
    input  ffbh_pkg::ffbh_cmd_t         cmd,
    output ffbh_pkg::ffbh_sts_t         sts,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [ffbh_pkg::OUT_W-1:0]  out_data,
    output logic                        out_last
);

    localparam int AW = (HEAP_BYTES > 1) ? $clog2(HEAP_BYTES) : 1;
    localparam logic [ffbh_pkg::PW-1:0] END_LIM = ffbh_pkg::PW'(HEAP_BYTES - 2);
    localparam logic [7:0] RST_SZ = 8'(((HEAP_BYTES - 2) << 1)) & ffbh_pkg::SIZE_MASK;

    // Heap memory with per-byte valid bits standing in for the reset image
    logic [7:0]            mem [HEAP_BYTES];
    logic [HEAP_BYTES-1:0] vld_reg;
    logic [7:0]            rd_a_reg, rd_b_reg;
    logic [AW-1:0]         ra, rb, wa;
    logic [7:0]            wd;

    // Item and walk registers
    ffbh_pkg::op_t           op_reg;
    logic [7:0]              id_reg, fb_reg;
    logic [6:0]              amt_reg;
    logic [ffbh_pkg::PW-1:0] pos_reg;
    logic [7:0]              hb0_reg, hb1_reg, byte_reg, next_id_reg;
    logic [6:0]              cnt_reg;
    logic [5:0]              n_reg;

    // Output register
    logic                    ovalid_reg;
    logic [ffbh_pkg::OUT_W-1:0] odata_reg, odata_next;
    logic                    olast_reg, olast_next;

    logic [6:0]              sz_cur, sz_l, surplus, off;
    logic [ffbh_pkg::PW-1:0] nxt_cur, nxt_l, pos_p2;
    logic                    end_l;

    function automatic logic [7:0] rst_byte(input logic [AW-1:0] a);
        return (a == AW'(1)) ? RST_SZ : 8'h00;
    endfunction

    // Block geometry from the fresh header read and from the latched one
    assign sz_cur  = rd_b_reg[7:1];
    assign nxt_cur = pos_reg + ffbh_pkg::PW'(2) + ffbh_pkg::PW'(sz_cur);
    assign sz_l    = hb1_reg[7:1];
    assign nxt_l   = pos_reg + ffbh_pkg::PW'(2) + ffbh_pkg::PW'(sz_l);
    assign end_l   = nxt_l > END_LIM;
    assign surplus = sz_l - amt_reg;
    assign pos_p2  = pos_reg + ffbh_pkg::PW'(2);
    assign off     = (amt_reg > sz_l - 7'd1) ? (sz_l - 7'd1) : amt_reg;

    // Read addresses
    always_comb
    begin
        ra = pos_reg[AW-1:0];
        rb = AW'(pos_reg + ffbh_pkg::PW'(1));
        case (cmd.rsel)
            ffbh_pkg::RS_BYTE: ra = AW'(pos_p2 + ffbh_pkg::PW'(off));
            default:           ra = pos_reg[AW-1:0];
        endcase
    end

    // Write address and data
    always_comb
    begin
        wa = pos_reg[AW-1:0];
        wd = next_id_reg;
        case (cmd.wsel)
            ffbh_pkg::WS_REM_ID:
            begin
                wa = AW'(pos_p2 + ffbh_pkg::PW'(amt_reg));
                wd = 8'h00;
            end
            ffbh_pkg::WS_REM_SZ:
            begin
                wa = AW'(pos_p2 + ffbh_pkg::PW'(amt_reg) + ffbh_pkg::PW'(1));
                wd = {7'(surplus - ffbh_pkg::SPLIT_MIN), 1'b0};
            end
            ffbh_pkg::WS_ID:
            begin
                wa = pos_reg[AW-1:0];
                wd = next_id_reg;
            end
            ffbh_pkg::WS_SZ_AMT:
            begin
                wa = AW'(pos_reg + ffbh_pkg::PW'(1));
                wd = {amt_reg, 1'b0} | ffbh_pkg::ALLOC_BIT;
            end
            ffbh_pkg::WS_SZ_KEEP:
            begin
                wa = AW'(pos_reg + ffbh_pkg::PW'(1));
                wd = {sz_l, 1'b0} | ffbh_pkg::ALLOC_BIT;
            end
            ffbh_pkg::WS_FREE:
            begin
                wa = AW'(pos_reg + ffbh_pkg::PW'(1));
                wd = hb1_reg & ffbh_pkg::SIZE_MASK;
            end
            ffbh_pkg::WS_FILL:
            begin
                wa = AW'(pos_p2 + ffbh_pkg::PW'(cnt_reg));
                wd = fb_reg;
            end
            default:
            begin
                wa = pos_reg[AW-1:0];
                wd = next_id_reg;
            end
        endcase
    end

    // Memory write and registered reads
    always_ff @(posedge clk)
    begin
        if (cmd.we)
            mem[wa] <= wd;
        rd_a_reg <= vld_reg[ra] ? mem[ra] : rst_byte(ra);
        rd_b_reg <= vld_reg[rb] ? mem[rb] : rst_byte(rb);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (cmd.we)
            vld_reg[wa] <= 1'b1;
    end

    // Item fields, latched header and fill byte capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg  <= ffbh_pkg::op_t'(in_data[2:0]);
            id_reg  <= in_data[10:3];
            amt_reg <= in_data[17:11];
            fb_reg  <= in_data[25:18];
        end
        if (cmd.cap)
        begin
            hb0_reg <= rd_a_reg;
            hb1_reg <= rd_b_reg;
        end
        if (cmd.cap_byte)
            byte_reg <= rd_a_reg;
    end

    // Walk position, counters and id allocator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            cnt_reg     <= '0;
            n_reg       <= '0;
            next_id_reg <= 8'd1;
        end
        else
        begin
            if (cmd.load_in)
            begin
                pos_reg <= '0;
                cnt_reg <= '0;
                n_reg   <= '0;
            end
            else
            begin
                if (cmd.adv_cur)
                    pos_reg <= nxt_cur;
                else if (cmd.adv_lat)
                    pos_reg <= nxt_l;
                if (cmd.cnt_inc)
                    cnt_reg <= cnt_reg + 7'd1;
                if (cmd.n_inc)
                    n_reg <= n_reg + 6'd1;
            end
            if (cmd.load_out && cmd.res_kind == ffbh_pkg::RK_ALLOC)
                next_id_reg <= next_id_reg + 8'd1;
        end
    end

    // Status to the controller
    always_comb
    begin
        sts.op        = op_reg;
        sts.fit       = !rd_b_reg[0] && (sz_cur >= amt_reg);
        sts.match     = rd_a_reg == id_reg;
        sts.at_end    = nxt_cur > END_LIM;
        sts.split     = surplus > ffbh_pkg::SPLIT_MIN;
        sts.fill_big  = amt_reg > sz_l;
        sts.sz_zero   = sz_l == 7'd0;
        sts.used      = hb1_reg[0];
        sts.lst_last  = end_l || (&n_reg);
        sts.fill_done = cnt_reg == amt_reg;
        sts.out_free  = !ovalid_reg || out_ready;
    end

    // Result word: status, id, byte, header, total, in use, start, end
    always_comb
    begin
        odata_next      = '0;
        odata_next[1:0] = cmd.res_status;
        olast_next      = 1'b1;
        case (cmd.res_kind)
            ffbh_pkg::RK_ALLOC:
                odata_next[9:2] = next_id_reg;
            ffbh_pkg::RK_READ:
                odata_next[17:10] = byte_reg;
            ffbh_pkg::RK_HDR:
                odata_next[33:18] = {hb0_reg, 8'(hb1_reg + 8'd4)};
            ffbh_pkg::RK_LIST:
            begin
                odata_next[9:2]   = hb0_reg;
                odata_next[41:34] = {1'b0, sz_l} + 8'd2;
                odata_next[42]    = hb1_reg[0];
                odata_next[49:43] = pos_reg[6:0];
                odata_next[56:50] = 7'(pos_reg + ffbh_pkg::PW'(sz_l) + ffbh_pkg::PW'(1));
                olast_next        = end_l || (&n_reg);
            end
            default:
                olast_next = 1'b1;
        endcase
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (cmd.load_out)
            ovalid_reg <= 1'b1;
        else if (out_ready)
            ovalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            odata_reg <= odata_next;
            olast_reg <= olast_next;
        end
    end

    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;
    assign out_last  = olast_reg;

endmodule

@@ rtl/core/first_fit_block_heap_manager_core.sv @@
// First-fit block heap manager, top level: ties the controller to the datapath.
// Depends on ffbh_pkg, ffbh_ctrl and ffbh_dp.
//
// One item at a time. After an item is accepted the controller passes through a
// dispatch state; then every operation walks the block headers from offset 0,
// each block in a registered read of both header bytes and then a decide. A
// found block then takes an action state; allocate then writes the block's id
// and size bytes, first writing the remainder's id and size bytes when it splits;
// fill writes the fill byte into each position until the amount is written; read
// fetches the data byte and waits for it. Every result is loaded into the output
// register, waiting while the sink stalls. List gives one result per block. The heap
// memory has one write port, so split and fill write their bytes in turn. No clearing
// pass: per-byte valid bits present the reset heap image at once after reset.
module first_fit_block_heap_manager_core
#(
    parameter int HEAP_BYTES = ffbh_pkg::HEAP_BYTES_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // opcode[2:0], block_id[10:3], amount[17:11], fill_byte[25:18], zero pad
    input  logic [ffbh_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // status[1:0], result_id[9:2], data_byte[17:10], header_word[33:18],
    // total_size[41:34], in_use[42], start_offset[49:43], end_offset[56:50], zero pad
    output logic [ffbh_pkg::OUT_W-1:0] m_axis_tdata,
    output logic                       m_axis_tlast
);

    ffbh_pkg::ffbh_cmd_t cmd;
    ffbh_pkg::ffbh_sts_t sts;
    logic                in_fire;

    assign in_fire = s_axis_tvalid && s_axis_tready;

    ffbh_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ffbh_dp #(
        .HEAP_BYTES (HEAP_BYTES)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_axis_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule
